>>> rtl/binary_trie_max_xor_assert.svh
// Assertion macros used by the trie engine.
`ifndef BINARY_TRIE_MAX_XOR_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define BTMX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btmx: assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define BTMX_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("btmx: forbidden condition seen");

`else

`define BTMX_ASSERT(lbl, clk, rst_n, prop)
`define BTMX_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/btmx_pkg.sv
`timescale 1ns / 1ps

package btmx_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POOL_NODES = 8192;
  localparam int OUT_W      = 32;

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int FREE_W = NODE_W + 1;
  localparam int LVL_W  = $clog2(VALUE_BITS);

  // Two child links per node, indexed by the branch bit; zero means no child.
  typedef logic [1:0][NODE_W-1:0] btmx_ent_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    btmx_ent_t         wdata;
    logic [NODE_W-1:0] raddr;
  } btmx_mem_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] pair_xor;
    logic [OUT_W-1:0] running_max;
    logic             pool_full;
  } btmx_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_INS_WALK,
    ST_ALLOC,
    ST_LEAF,
    ST_DONE
  } btmx_state_e;

endpackage

>>> rtl/btmx_req_if.sv
`timescale 1ns / 1ps

interface btmx_req_if import btmx_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        first;

  modport source (output valid, output value, output first, input ready);
  modport sink (input valid, input value, input first, output ready);
endinterface

>>> rtl/btmx_res_if.sv
`timescale 1ns / 1ps

interface btmx_res_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pair_xor;
  logic [OUT_W-1:0] running_max;
  logic             pool_full;

  modport source (output valid, output pair_xor, output running_max, output pool_full,
                  input ready);
  modport sink (input valid, input pair_xor, input running_max, input pool_full,
                output ready);
endinterface

>>> rtl/binary_trie_max_xor.sv
`timescale 1ns / 1ps

// Maximum-XOR pair over a stream of 32-bit words. Each request is matched against a binary
// trie of the earlier words of the current set (largest XOR found by a top-down walk that
// prefers the opposite branch), then inserted; the result gives that pair XOR, the running
// maximum of the set and a sticky pool-full flag. A request with first set restarts the set.
// One walker visits the trie one level per cycle over the single 8192 x 26 node memory: a
// query walk (none on a first request or an empty set), an insert walk down the existing
// path, then one allocation step per new node and a leaf write when nodes are added. Root
// links sit in flops, so no clearing pass is needed after reset. A finished result waits in
// an output register while the next request is taken.
module binary_trie_max_xor import btmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  btmx_req_if.sink   req_i,
  btmx_res_if.source res_o
);

  logic          eng_res_valid, eng_res_ready;
  btmx_res_t     eng_res;
  btmx_mem_req_t mem_req;
  btmx_ent_t     mem_rdata;

  logic      out_valid_q, out_valid_d;
  btmx_res_t out_q, out_d;

  btmx_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_value_i  (req_i.value),
    .in_first_i  (req_i.first),
    .res_valid_o (eng_res_valid),
    .res_ready_i (eng_res_ready),
    .res_o       (eng_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  btmx_ram #(
    .WIDTH ($bits(btmx_ent_t)),
    .DEPTH (POOL_NODES)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign eng_res_ready = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (eng_res_valid && eng_res_ready) begin
      out_valid_d = 1'b1;
      out_d       = eng_res;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pair_xor    = out_q.pair_xor;
  assign res_o.running_max = out_q.running_max;
  assign res_o.pool_full   = out_q.pool_full;

endmodule

>>> rtl/btmx_ram.sv
`timescale 1ns / 1ps

module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/btmx_engine.sv
`timescale 1ns / 1ps

`include "binary_trie_max_xor_assert.svh"

module btmx_engine import btmx_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   in_value_i,
  input  logic          in_first_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output btmx_res_t     res_o,
  output btmx_mem_req_t mem_req_o,
  input  btmx_ent_t     mem_rdata_i
);

  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(VALUE_BITS - 1);

  btmx_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d, acc_n;
  logic [VALUE_BITS-1:0] px_q, px_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [NODE_W-1:0]     node_q, node_d;
  logic [FREE_W-1:0]     free_q, free_d;
  btmx_ent_t             root_q, root_d;
  btmx_ent_t             par_ent_q, par_ent_d;
  logic                  fresh_q, fresh_d;
  logic                  ovf_q, ovf_d;

  btmx_ent_t         ent, new_ent;
  logic              bit_v;
  logic [NODE_W-1:0] want, same, qnext;
  logic [LVL_W:0]    needed;
  logic [FREE_W-1:0] room;

  // Root links live in flops so an empty trie reads correctly straight after reset.
  assign ent    = (node_q == '0) ? root_q : mem_rdata_i;
  assign bit_v  = val_q[lvl_q];
  assign want   = ent[~bit_v];
  assign same   = ent[bit_v];
  assign qnext  = (want != '0) ? want : same;
  assign needed = {1'b0, lvl_q} + (LVL_W + 1)'(1);
  assign room   = FREE_W'(POOL_NODES) - free_q;

  always_comb begin
    acc_n = acc_q;
    if (want != '0) begin
      acc_n[lvl_q] = 1'b1;
    end
    new_ent = fresh_q ? '0 : par_ent_q;
    new_ent[bit_v] = free_q[NODE_W-1:0];
  end

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    acc_d     = acc_q;
    px_d      = px_q;
    best_d    = best_q;
    lvl_d     = lvl_q;
    node_d    = node_q;
    free_d    = free_q;
    root_d    = root_q;
    par_ent_d = par_ent_q;
    fresh_d   = fresh_q;
    ovf_d     = ovf_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o   = '{we: 1'b0, waddr: node_q, wdata: new_ent, raddr: qnext};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d  = VALUE_BITS'(in_value_i);
          lvl_d  = TOP_LVL;
          node_d = '0;
          acc_d  = '0;
          px_d   = '0;
          if (in_first_i) begin
            root_d  = '0;
            free_d  = FREE_W'(1);
            best_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_INS_WALK;
          end else if (free_q <= FREE_W'(1)) begin
            state_d = ST_INS_WALK;
          end else begin
            state_d = ST_QUERY;
          end
        end
      end

      ST_QUERY: begin
        mem_req_o.raddr = qnext;
        if (qnext == '0 || lvl_q == '0) begin
          px_d = acc_n;
          if (acc_n > best_q) begin
            best_d = acc_n;
          end
          node_d  = '0;
          lvl_d   = TOP_LVL;
          state_d = ST_INS_WALK;
        end else begin
          acc_d  = acc_n;
          node_d = qnext;
          lvl_d  = lvl_q - LVL_W'(1);
        end
      end

      ST_INS_WALK: begin
        mem_req_o.raddr = same;
        if (same == '0) begin
          par_ent_d = ent;
          fresh_d   = 1'b0;
          // All-or-nothing insert: no partial path if the pool cannot take it.
          if (room < FREE_W'(needed)) begin
            ovf_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_ALLOC;
          end
        end else if (lvl_q == '0) begin
          state_d = ST_DONE;
        end else begin
          node_d = same;
          lvl_d  = lvl_q - LVL_W'(1);
        end
      end

      ST_ALLOC: begin
        if (node_q == '0) begin
          root_d = new_ent;
        end else begin
          mem_req_o.we = 1'b1;
        end
        node_d  = free_q[NODE_W-1:0];
        free_d  = free_q + FREE_W'(1);
        fresh_d = 1'b1;
        if (lvl_q == '0) begin
          state_d = ST_LEAF;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end

      ST_LEAF: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = '0;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = '{pair_xor: OUT_W'(px_q), running_max: OUT_W'(best_q), pool_full: ovf_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      free_q  <= FREE_W'(1);
      best_q  <= '0;
      ovf_q   <= 1'b0;
      root_q  <= '0;
      lvl_q   <= '0;
      node_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      best_q  <= best_d;
      ovf_q   <= ovf_d;
      root_q  <= root_d;
      lvl_q   <= lvl_d;
      node_q  <= node_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    acc_q     <= acc_d;
    px_q      <= px_d;
    par_ent_q <= par_ent_d;
  end

  `BTMX_NEVER(a_free_bound, clk_i, rst_ni, free_q > FREE_W'(POOL_NODES) || free_q == '0)
  `BTMX_NEVER(a_no_root_write, clk_i, rst_ni, mem_req_o.we && mem_req_o.waddr == '0)
  `BTMX_ASSERT(a_max_covers_pair, clk_i, rst_ni, res_valid_o |-> res_o.running_max >= res_o.pair_xor)
  `BTMX_ASSERT(a_full_sticky, clk_i, rst_ni, $fell(ovf_q) |-> $past(in_valid_i && in_ready_o && in_first_i))

endmodule
